>>> rtl/assert_macros.svh
// assertion helpers for the checker in lss_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, inactive during reset
`define LSS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lss assertion failed");

// next-cycle implication, inactive during reset
`define LSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lss assertion failed");

`endif

>>> rtl/lss_pkg.sv
package lss_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int HIT_GROUP_W = 8;
    localparam int HIT_GROUPS  = (STACK_DEPTH + HIT_GROUP_W - 1) / HIT_GROUP_W;

    typedef enum logic [1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_TOP    = 2'd2,
        ACT_SEARCH = 2'd3
    } lss_action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } lss_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HIT,
        S_FOUND
    } lss_state_t;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic                     push;
        logic                     pop;
        logic                     search;
        logic signed [DATA_W-1:0] key;
    } lss_cell_ctl_t;

endpackage

>>> rtl/lss_if.sv
interface lss_req_if import lss_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               action;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface lss_rsp_if import lss_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] data;
    logic                     found;
    logic [1:0]               status;
    logic [COUNT_W-1:0]       depth_now;

    modport source (output valid, output data, output found, output status,
                    output depth_now, input ready);
    modport sink   (input valid, input data, input found, input status,
                    input depth_now, output ready);
endinterface

>>> rtl/lss_cell.sv
module lss_cell import lss_pkg::*; (
    input  logic                     clk,
    input  lss_cell_ctl_t            ctl,
    input  logic                     held,
    input  logic signed [DATA_W-1:0] upper_word,
    input  logic signed [DATA_W-1:0] lower_word,
    output logic signed [DATA_W-1:0] word,
    output logic                     hit
);

    logic signed [DATA_W-1:0] word_reg;
    logic signed [DATA_W-1:0] word_next;
    logic                     hit_reg;
    logic                     hit_next;

    always_comb
    begin
        word_next = word_reg;
        hit_next  = hit_reg;
        if (ctl.push)
        begin
            word_next = upper_word;
        end
        else if (ctl.pop)
        begin
            word_next = lower_word;
        end
        if (ctl.search)
        begin
            hit_next = held && (word_reg == ctl.key);
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        hit_reg  <= hit_next;
    end

    assign word = word_reg;
    assign hit  = hit_reg;

endmodule

>>> rtl/lss_hit_reduce.sv
module lss_hit_reduce import lss_pkg::*; (
    input  logic                   clk,
    input  logic [STACK_DEPTH-1:0] hits,
    output logic                   found
);

    logic [HIT_GROUPS-1:0] group_reg;
    logic [HIT_GROUPS-1:0] group_next;

    // first level: or of each group of cells
    always_comb
    begin
        group_next = '0;
        for (int g = 0; g < HIT_GROUPS; g++)
        begin
            for (int k = 0; k < HIT_GROUP_W; k++)
            begin
                if (g * HIT_GROUP_W + k < STACK_DEPTH)
                begin
                    group_next[g] = group_next[g] | hits[g * HIT_GROUP_W + k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        group_reg <= group_next;
    end

    // second level
    assign found = |group_reg;

endmodule

>>> rtl/lifo_stack_with_search.sv
// channel | dir | handshake    | payload
// req     | in  | valid/ready  | action[1:0], value[31:0] signed
// rsp     | out | valid/ready  | data[31:0] signed, found, status[1:0], depth_now[6:0]
//
// push, pop and read top: one transfer per cycle while rsp drains; the result sits
//   in the output register the cycle after the req transfer
// search: the result passes the cell compare register, the registered first level of
//   the or over the 64 cells and the output register; req.ready is low meanwhile
// reset clears the entry count, the fsm and the output valid; cell words are not reset
// a stalled rsp holds req.ready low only while the output register stays full
module lifo_stack_with_search import lss_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    lss_req_if.sink   req,
    lss_rsp_if.source rsp
);

    // control state
    lss_state_t               state_reg;
    lss_state_t               state_next;
    logic [COUNT_W-1:0]       count_reg;
    logic [COUNT_W-1:0]       count_next;

    // output register
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     found_reg;
    logic                     found_next;
    lss_status_t              status_reg;
    lss_status_t              status_next;
    logic [COUNT_W-1:0]       depth_reg;
    logic [COUNT_W-1:0]       depth_next;

    // cell chain
    lss_cell_ctl_t            cell_ctl;
    logic signed [DATA_W-1:0] words [STACK_DEPTH];
    logic [STACK_DEPTH-1:0]   held;
    logic [STACK_DEPTH-1:0]   hits;
    logic                     search_found;

    logic                     in_fire;
    logic                     is_empty;
    logic                     is_full;

    // new work only when idle and the output slot is free or draining
    assign req.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign in_fire   = req.valid && req.ready;
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == COUNT_W'(STACK_DEPTH));

    // cell 0 is the top of stack; a push moves every word one cell down
    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] upper;
        logic signed [DATA_W-1:0] lower;

        if (i == 0)
        begin : g_top
            assign upper = req.value;
        end
        else
        begin : g_mid
            assign upper = words[i-1];
        end

        if (i == STACK_DEPTH - 1)
        begin : g_bottom
            assign lower = '0;
        end
        else
        begin : g_inner
            assign lower = words[i+1];
        end

        // only cells below the count take part in a search
        assign held[i] = (count_reg > COUNT_W'(i));

        lss_cell u_cell (
            .clk        (clk),
            .ctl        (cell_ctl),
            .held       (held[i]),
            .upper_word (upper),
            .lower_word (lower),
            .word       (words[i]),
            .hit        (hits[i])
        );
    end

    lss_hit_reduce u_reduce (
        .clk   (clk),
        .hits  (hits),
        .found (search_found)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        data_next       = data_reg;
        found_next      = found_reg;
        status_next     = status_reg;
        depth_next      = depth_reg;
        cell_ctl.push   = 1'b0;
        cell_ctl.pop    = 1'b0;
        cell_ctl.search = 1'b0;
        cell_ctl.key    = req.value;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    found_next  = 1'b0;
                    data_next   = '0;
                    status_next = ST_OK;
                    case (lss_action_t'(req.action))
                        ACT_PUSH:
                        begin
                            if (is_full)
                            begin
                                // word dropped, stack untouched
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                cell_ctl.push = 1'b1;
                                count_next    = count_reg + COUNT_W'(1);
                            end
                            out_valid_next = 1'b1;
                        end
                        ACT_POP:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                cell_ctl.pop = 1'b1;
                                count_next   = count_reg - COUNT_W'(1);
                                data_next    = words[0];
                            end
                            out_valid_next = 1'b1;
                        end
                        ACT_TOP:
                        begin
                            if (is_empty)
                            begin
                                // empty read top answers all ones
                                status_next = ST_EMPTY;
                                data_next   = '1;
                            end
                            else
                            begin
                                data_next = words[0];
                            end
                            out_valid_next = 1'b1;
                        end
                        ACT_SEARCH:
                        begin
                            // cells register their compare this edge
                            cell_ctl.search = 1'b1;
                            state_next      = S_HIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                    depth_next = count_next;
                end
            end
            S_HIT:
            begin
                // group or registers this edge
                state_next = S_FOUND;
            end
            S_FOUND:
            begin
                // output slot is known free: it drained when the search was taken
                out_valid_next = 1'b1;
                data_next      = '0;
                found_next     = search_found;
                status_next    = ST_OK;
                depth_next     = count_reg;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        data_reg   <= data_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        depth_reg  <= depth_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.data      = data_reg;
    assign rsp.found     = found_reg;
    assign rsp.status    = status_reg;
    assign rsp.depth_now = depth_reg;

endmodule

>>> rtl/lss_checker.sv
`include "assert_macros.svh"

module lss_checker import lss_pkg::*; (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     rsp_valid,
    input logic                     rsp_ready,
    input logic signed [DATA_W-1:0] rsp_data,
    input logic                     rsp_found,
    input logic [1:0]               rsp_status,
    input logic [COUNT_W-1:0]       rsp_depth_now
);

    // a stalled result stays offered and unchanged
    `LSS_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    `LSS_ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_valid && !rsp_ready, $stable(rsp_data) && $stable(rsp_found) && $stable(rsp_status) && $stable(rsp_depth_now))

    // empty answers leave nothing held and carry only the empty codes
    `LSS_ASSERT_SAME(a_empty, clk, rst_n, rsp_valid && (rsp_status == ST_EMPTY), (rsp_depth_now == '0) && !rsp_found && ((rsp_data == '0) || (rsp_data == '1)))

    // a dropped push only happens with every cell in use
    `LSS_ASSERT_SAME(a_full, clk, rst_n, rsp_valid && (rsp_status == ST_FULL), (rsp_depth_now == COUNT_W'(STACK_DEPTH)) && (rsp_data == '0) && !rsp_found)

    // a hit is only reported by a search
    `LSS_ASSERT_SAME(a_found, clk, rst_n, rsp_valid && rsp_found, (rsp_status == ST_OK) && (rsp_data == '0) && (rsp_depth_now != '0))

endmodule

bind lifo_stack_with_search lss_checker u_lss_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_data      (rsp.data),
    .rsp_found     (rsp.found),
    .rsp_status    (rsp.status),
    .rsp_depth_now (rsp.depth_now)
);

>>> test/tb_lifo_stack_with_search.sv
`timescale 1ns / 100ps

module tb_lifo_stack_with_search;
    import lss_pkg::*;

    // item count for the whole run, and the idle limit of the watchdog
    localparam int ITEM_TARGET = 1650;
    localparam int IDLE_LIMIT  = 2000;
    // cycles to linger after the last reply
    localparam int TAIL_CYCLES = 20;

    // one reply as the block should present it
    typedef struct {
        logic signed [DATA_W-1:0] data;
        logic                     found;
        lss_status_t              status;
        logic [COUNT_W-1:0]       depth_now;
    } stack_reply_t;

    // mirror of the stack: applies each accepted request to its own copy of
    // the entries and queues the reply that request must produce
    class stack_mirror;
        logic signed [DATA_W-1:0] words [STACK_DEPTH];
        int                       held;
        stack_reply_t             replies_due [$];
        int                       errors;

        function void note_request(lss_action_t act, logic signed [DATA_W-1:0] val);
            stack_reply_t r;
            r.data   = '0;
            r.found  = 1'b0;
            r.status = ST_OK;
            case (act)
                ACT_PUSH:
                begin
                    // a push onto a full stack is dropped
                    if (held >= STACK_DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        words[held] = val;
                        held++;
                    end
                end
                ACT_POP:
                begin
                    // pop on empty answers zero and leaves the stack alone
                    if (held == 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        held--;
                        r.data = words[held];
                    end
                end
                ACT_TOP:
                begin
                    // read top on empty answers all ones
                    if (held == 0)
                    begin
                        r.status = ST_EMPTY;
                        r.data   = -1;
                    end
                    else
                        r.data = words[held-1];
                end
                default:
                begin
                    // search looks at held entries only
                    for (int i = 0; i < held; i++)
                        if (words[i] == val)
                            r.found = 1'b1;
                end
            endcase
            r.depth_now = COUNT_W'(held);
            replies_due.push_back(r);
        endfunction

        function void check_reply(logic signed [DATA_W-1:0] d, logic f, logic [1:0] s,
                                  logic [COUNT_W-1:0] n);
            stack_reply_t r;
            if (replies_due.size() == 0)
            begin
                $error("reply with no request pending: data %0d", d);
                errors++;
                return;
            end
            r = replies_due.pop_front();
            if (d !== r.data)
            begin
                $error("data: expected %0d, actual %0d", r.data, d);
                errors++;
            end
            if (f !== r.found)
            begin
                $error("found: expected %0d, actual %0d", r.found, f);
                errors++;
            end
            if (s !== r.status)
            begin
                $error("status: expected %0d, actual %0d", r.status, s);
                errors++;
            end
            if (n !== r.depth_now)
            begin
                $error("depth_now: expected %0d, actual %0d", r.depth_now, n);
                errors++;
            end
        endfunction

        // a word now on the stack, so searches and duplicate pushes hit
        function logic signed [DATA_W-1:0] pick_held();
            if (held == 0)
                return $urandom;
            return words[$urandom_range(0, held - 1)];
        endfunction
    endclass

    logic clk;
    logic rst_n;

    lss_req_if req ();
    lss_rsp_if rsp ();

    lifo_stack_with_search dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    stack_mirror mirror = new();

    int sent;
    int send_calm;
    int recv_calm;
    int idle_cycles = 0;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // idle cycles before the next transfer; now and then a calm stretch
    // with no idling at all
    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            calm = $urandom_range(10, 40);
        return $urandom_range(0, 13);
    endfunction

    // mostly random words, with the extremes and held words mixed in
    function automatic logic signed [DATA_W-1:0] some_word();
        int pick;
        pick = $urandom_range(0, 19);
        case (pick)
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -1;
            4, 5, 6: return mirror.pick_held();
            default: return $urandom;
        endcase
    endfunction

    // search key: half the time a held word, otherwise anything
    function automatic logic signed [DATA_W-1:0] search_key();
        if ($urandom_range(0, 1) == 0)
            return mirror.pick_held();
        return some_word();
    endfunction

    // one request transfer: idle for a drawn gap, then hold valid until ready
    task automatic send_req(lss_action_t act, logic signed [DATA_W-1:0] val);
        int gap;
        gap = draw_gap(send_calm);
        repeat (gap)
        begin
            @(negedge clk);
            req.valid <= 1'b0;
        end
        @(negedge clk);
        req.valid  <= 1'b1;
        req.action <= act;
        req.value  <= val;
        do
            @(posedge clk);
        while (!req.ready);
        mirror.note_request(act, val);
        sent++;
    endtask

    // hold off the sender until every reply has come back
    task automatic wait_drained();
        @(negedge clk);
        req.valid <= 1'b0;
        while (mirror.replies_due.size() != 0)
            @(posedge clk);
    endtask

    // push, with some reads and searches, until full, then a few dropped pushes and two searches over all cells
    task automatic fill_episode();
        int extra;
        while (mirror.held < STACK_DEPTH)
        begin
            case ($urandom_range(0, 9))
                0:       send_req(ACT_TOP, $urandom);
                1:       send_req(ACT_SEARCH, search_key());
                default: send_req(ACT_PUSH, some_word());
            endcase
        end
        extra = $urandom_range(1, 4);
        repeat (extra)
            send_req(ACT_PUSH, $urandom);
        send_req(ACT_SEARCH, mirror.words[0]);
        send_req(ACT_SEARCH, search_key());
    endtask

    // pop, with some reads and searches, until empty, then pops, reads and searches on the empty stack
    task automatic drain_episode();
        int extra;
        while (mirror.held > 0)
        begin
            case ($urandom_range(0, 9))
                0:       send_req(ACT_TOP, $urandom);
                1:       send_req(ACT_SEARCH, search_key());
                default: send_req(ACT_POP, $urandom);
            endcase
        end
        extra = $urandom_range(1, 3);
        repeat (extra)
        begin
            case ($urandom_range(0, 2))
                0:       send_req(ACT_POP, $urandom);
                1:       send_req(ACT_TOP, $urandom);
                default: send_req(ACT_SEARCH, $urandom);
            endcase
        end
    endtask

    // free mix of all actions around the current depth
    task automatic mixed_episode();
        int len;
        int pick;
        len = $urandom_range(20, 60);
        repeat (len)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                send_req(ACT_PUSH, some_word());
            else if (pick < 65)
                send_req(ACT_POP, $urandom);
            else if (pick < 80)
                send_req(ACT_TOP, $urandom);
            else
                send_req(ACT_SEARCH, search_key());
        end
    endtask

    // reply side: idle for a drawn gap, then take one reply
    initial
    begin : reply_side
        int gap;
        rsp.ready = 1'b0;
        recv_calm = 0;
        forever
        begin
            gap = draw_gap(recv_calm);
            repeat (gap)
            begin
                @(negedge clk);
                rsp.ready <= 1'b0;
            end
            @(negedge clk);
            rsp.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp.valid);
            mirror.check_reply(rsp.data, rsp.found, rsp.status, rsp.depth_now);
        end
    end

    // watchdog: a stretch past IDLE_LIMIT with no transfer on either side ends the run with an error
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[lifo_stack_with_search] ERROR");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : request_side
        int next_pause;
        int kind;
        req.valid   = 1'b0;
        req.action  = ACT_PUSH;
        req.value   = '0;
        rst_n       = 1'b0;
        sent        = 0;
        send_calm   = 0;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty-stack answers, extreme words, hits and misses
        send_req(ACT_POP, 32'sh1234_5678);
        send_req(ACT_TOP, '0);
        send_req(ACT_SEARCH, '0);
        send_req(ACT_PUSH, 32'sh8000_0000);
        send_req(ACT_PUSH, 32'sh7fff_ffff);
        send_req(ACT_PUSH, '0);
        send_req(ACT_PUSH, -1);
        send_req(ACT_TOP, 32'sh7fff_ffff);
        send_req(ACT_SEARCH, 32'sh8000_0000);
        send_req(ACT_SEARCH, 32'sh7fff_ffff);
        send_req(ACT_SEARCH, 32'sh0000_3039);
        send_req(ACT_POP, -1);
        send_req(ACT_POP, '0);
        send_req(ACT_TOP, '0);
        send_req(ACT_SEARCH, -1);
        send_req(ACT_POP, '0);
        send_req(ACT_POP, '0);
        send_req(ACT_POP, '0);
        send_req(ACT_TOP, -1);
        send_req(ACT_SEARCH, 32'sh8000_0000);
        send_req(ACT_PUSH, 32'sh5555_5555);
        send_req(ACT_PUSH, 32'shaaaa_aaaa);
        send_req(ACT_SEARCH, 32'shaaaa_aaaa);
        send_req(ACT_POP, 32'sh5555_5555);
        send_req(ACT_POP, 32'shaaaa_aaaa);
        wait_drained();

        // random: fill and drain runs reach full and empty, mixed runs between
        next_pause = sent + 300;
        while (sent < ITEM_TARGET)
        begin
            kind = $urandom_range(0, 3);
            case (kind)
                0:       fill_episode();
                1:       drain_episode();
                default: mixed_episode();
            endcase
            if (sent >= next_pause)
            begin
                wait_drained();
                next_pause += 300;
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (mirror.replies_due.size() != 0)
        begin
            $error("%0d replies never arrived", mirror.replies_due.size());
            mirror.errors++;
        end
        if (mirror.errors == 0)
            $display("[lifo_stack_with_search] OK");
        else
            $display("[lifo_stack_with_search] ERROR");
        $finish;
    end

endmodule
